### rtl/sbct_pkg.sv
package sbct_pkg;

    // number of divider lanes: x entry, x exit, y entry, y exit
    localparam int NLANE = 4;
    localparam int LN_XE = 0;
    localparam int LN_XX = 1;
    localparam int LN_YE = 2;
    localparam int LN_YX = 3;

    // contact normal codes
    localparam logic signed [1:0] NORM_NEG  = -2'sd1;
    localparam logic signed [1:0] NORM_POS  = 2'sd1;
    localparam logic signed [1:0] NORM_NONE = 2'sd0;

    // per-word flags carried alongside the divider lanes
    typedef struct packed {
        logic rej;      // broad phase miss or no motion
        logic dx_pos;
        logic dy_pos;
        logic dx_zero;
        logic dy_zero;
    } t_side;

endpackage

### rtl/sbct_in_if.sv
interface sbct_in_if #(
    parameter int CB = 24
);
    logic                 valid;
    logic                 ready;
    logic signed [CB-1:0] mover_left;
    logic signed [CB-1:0] mover_top;
    logic signed [CB-1:0] mover_right;
    logic signed [CB-1:0] mover_bottom;
    logic signed [CB-1:0] move_x;
    logic signed [CB-1:0] move_y;
    logic signed [CB-1:0] fixed_left;
    logic signed [CB-1:0] fixed_top;
    logic signed [CB-1:0] fixed_right;
    logic signed [CB-1:0] fixed_bottom;

    modport source (
        output valid, mover_left, mover_top, mover_right, mover_bottom,
               move_x, move_y, fixed_left, fixed_top, fixed_right, fixed_bottom,
        input  ready
    );
    modport sink (
        input  valid, mover_left, mover_top, mover_right, mover_bottom,
               move_x, move_y, fixed_left, fixed_top, fixed_right, fixed_bottom,
        output ready
    );
endinterface

### rtl/sbct_out_if.sv
interface sbct_out_if #(
    parameter int FB = 16
);
    logic              valid;
    logic              ready;
    logic              hit;
    logic [FB:0]       entry_time;
    logic signed [1:0] normal_x;
    logic signed [1:0] normal_y;

    modport source (output valid, hit, entry_time, normal_x, normal_y, input ready);
    modport sink   (input valid, hit, entry_time, normal_x, normal_y, output ready);
endinterface

### rtl/swept_box_collision_time_top.sv
// Swept box collision time, 2D.
// Input channel i_in takes one word per pair: the moving box edges, its
// displacement for the frame and the static box edges, all signed fixed point.
// Output channel o_out gives one word per input word: hit flag, entry time
// (unsigned, TIME_FRAC_BITS fraction bits, 0 .. 1.0) and contact normal.
// Fields of a miss are all zero.
// Throughput: one word per cycle while the receiver takes words. Four per-axis
// quotients are formed by a row of COORD_BITS+TIME_FRAC_BITS+1 division cells,
// one quotient bit per cell per cycle unless stalled, all lanes side by side.
// An accepted word is loaded into the front register, then passes each cell of
// the row in order, then the output register that drives o_out.valid.
// Each stage advances on its own when the stage after it is free, so a
// stalled receiver first lets the row fill up; i_in.ready drops only when
// every stage holds a word. The held output word stays stable until taken.
// Reset clears all valid flags; no words are in flight afterward.
module swept_box_collision_time_top
    import sbct_pkg::*;
#(
    parameter int COORD_BITS     = 24,
    parameter int TIME_FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sbct_in_if.sink    i_in,
    sbct_out_if.source o_out
);
    localparam int CB = COORD_BITS;
    localparam int FB = TIME_FRAC_BITS;
    localparam int NS = CB + FB + 1;   // cells in the row
    localparam int TW = FB + 4;        // signed time width
    localparam logic [FB+2:0]         SAT   = (FB+3)'(1) << (FB + 1);
    localparam logic signed [TW-1:0]  T_ONE = TW'(1) <<< FB;
    localparam logic signed [TW-1:0]  T_INF = TW'(1) <<< (FB + 2);

    // stage arrays: 0 is the front register, 1..NS are cells
    logic          r_vld  [NS+1];
    t_side         r_side [NS+1];
    logic [CB:0]    r_rem [NS+1][NLANE];
    logic [CB+FB:0] r_x   [NS+1][NLANE];
    logic [CB-1:0]  r_d   [NS+1][NLANE];
    logic [FB+1:0]  r_q   [NS+1][NLANE];
    logic [NLANE-1:0] r_ovf [NS+1];
    logic [NLANE-1:0] r_neg [NS+1];
    logic [NS+1:0] w_en;

    // output register
    logic              r_ov;
    logic              r_hit;
    logic [FB:0]       r_et;
    logic signed [1:0] r_nx;
    logic signed [1:0] r_ny;

    // stage advance chain
    assign w_en[NS+1] = !r_ov || o_out.ready;
    for (genvar k = 0; k <= NS; k++) begin : g_en
        assign w_en[k] = !r_vld[k] || w_en[k+1];
    end
    assign i_in.ready = w_en[0];

    // front: swept bounds, broad phase, normalized dividends
    logic signed [CB:0] ml, mt, mr, mb, dx, dy, sl, st, sr, sb;
    logic signed [CB:0] bl, bt, br, bb;
    logic signed [CB:0] w_num [NLANE];
    logic [CB-1:0]      w_adx, w_ady;
    logic               w_dxp, w_dyp, w_dxz, w_dyz;
    t_side              w_side;

    always_comb begin
        ml = (CB+1)'(i_in.mover_left);
        mt = (CB+1)'(i_in.mover_top);
        mr = (CB+1)'(i_in.mover_right);
        mb = (CB+1)'(i_in.mover_bottom);
        dx = (CB+1)'(i_in.move_x);
        dy = (CB+1)'(i_in.move_y);
        sl = (CB+1)'(i_in.fixed_left);
        st = (CB+1)'(i_in.fixed_top);
        sr = (CB+1)'(i_in.fixed_right);
        sb = (CB+1)'(i_in.fixed_bottom);
        w_dxp = !dx[CB] && (dx != '0);
        w_dyp = !dy[CB] && (dy != '0);
        w_dxz = (dx == '0);
        w_dyz = (dy == '0);
        bl = w_dxp ? ml : ml + dx;
        bt = w_dyp ? mt : mt + dy;
        br = w_dxp ? mr + dx : mr;
        bb = w_dyp ? mb + dy : mb;
        w_side.rej     = (br < sl) || (bl > sr) || (bb < st) || (bt > sb)
                         || (w_dxz && w_dyz);
        w_side.dx_pos  = w_dxp;
        w_side.dy_pos  = w_dyp;
        w_side.dx_zero = w_dxz;
        w_side.dy_zero = w_dyz;
        w_adx = i_in.move_x[CB-1] ? CB'(-i_in.move_x) : CB'(i_in.move_x);
        w_ady = i_in.move_y[CB-1] ? CB'(-i_in.move_y) : CB'(i_in.move_y);
        // divisor made positive; dividend sign follows
        w_num[LN_XE] = w_dxp ? sl - mr : ml - sr;
        w_num[LN_XX] = w_dxp ? sr - ml : mr - sl;
        w_num[LN_YE] = w_dyp ? st - mb : mt - sb;
        w_num[LN_YX] = w_dyp ? sb - mt : mb - st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_en[0]) begin
            r_vld[0] <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_side[0] <= w_side;
            for (int l = 0; l < NLANE; l++) begin
                r_rem[0][l] <= '0;
                r_x[0][l]   <= {(w_num[l][CB] ? (CB+1)'(-w_num[l]) : (CB+1)'(w_num[l])),
                                FB'(0)};
                r_d[0][l]   <= (l < LN_YE) ? w_adx : w_ady;
                r_q[0][l]   <= '0;
                r_ovf[0][l] <= 1'b0;
                r_neg[0][l] <= w_num[l][CB];
            end
        end
    end

    // division cell row
    for (genvar k = 1; k <= NS; k++) begin : g_cell
        sbct_cell #(.CB(CB), .FB(FB)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en[k]),
            .i_vld  (r_vld[k-1]),
            .i_side (r_side[k-1]),
            .i_rem  (r_rem[k-1]),
            .i_x    (r_x[k-1]),
            .i_d    (r_d[k-1]),
            .i_q    (r_q[k-1]),
            .i_ovf  (r_ovf[k-1]),
            .i_neg  (r_neg[k-1]),
            .o_vld  (r_vld[k]),
            .o_side (r_side[k]),
            .o_rem  (r_rem[k]),
            .o_x    (r_x[k]),
            .o_d    (r_d[k]),
            .o_q    (r_q[k]),
            .o_ovf  (r_ovf[k]),
            .o_neg  (r_neg[k])
        );
    end

    // finish: floor correction, saturation, rejection, normal
    logic [FB+2:0]        w_mag [NLANE];
    logic signed [TW-1:0] w_t   [NLANE];
    logic signed [TW-1:0] txe, txx, tye, tyx, te, tx;
    t_side                w_fs;
    logic                 n_hit;
    logic [FB:0]          n_et;
    logic signed [1:0]    n_nx, n_ny;

    always_comb begin
        w_fs = r_side[NS];
        for (int l = 0; l < NLANE; l++) begin
            w_mag[l] = {1'b0, r_q[NS][l]}
                       + (FB+3)'(r_neg[NS][l] && (r_rem[NS][l] != '0));
            if (r_ovf[NS][l] || (w_mag[l] > SAT)) begin
                w_mag[l] = SAT;
            end
            w_t[l] = r_neg[NS][l] ? -$signed({1'b0, w_mag[l]}) : $signed({1'b0, w_mag[l]});
        end
        txe = w_fs.dx_zero ? -T_INF : w_t[LN_XE];
        txx = w_fs.dx_zero ?  T_INF : w_t[LN_XX];
        tye = w_fs.dy_zero ? -T_INF : w_t[LN_YE];
        tyx = w_fs.dy_zero ?  T_INF : w_t[LN_YX];
        te  = (txe > tye) ? txe : tye;
        tx  = (txx < tyx) ? txx : tyx;
        n_hit = !(w_fs.rej || (txe < 0 && tye < 0) || (txe > T_ONE) || (tye > T_ONE)
                  || (te > tx));
        n_et = n_hit ? te[FB:0] : '0;
        n_nx = NORM_NONE;
        n_ny = NORM_NONE;
        if (n_hit) begin
            if (txe > tye) begin
                n_nx = w_fs.dx_pos ? NORM_NEG : NORM_POS;
            end else begin
                n_ny = w_fs.dy_pos ? NORM_NEG : NORM_POS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en[NS+1]) begin
            r_ov <= r_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NS+1]) begin
            r_hit <= n_hit;
            r_et  <= n_et;
            r_nx  <= n_nx;
            r_ny  <= n_ny;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.hit        = r_hit;
    assign o_out.entry_time = r_et;
    assign o_out.normal_x   = r_nx;
    assign o_out.normal_y   = r_ny;
endmodule

### rtl/sbct_cell.sv
// One restoring-division step for all four lanes, plus the word's flags.
module sbct_cell
    import sbct_pkg::*;
#(
    parameter int CB = 24,
    parameter int FB = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  t_side         i_side,
    input  logic [CB:0]    i_rem [NLANE],
    input  logic [CB+FB:0] i_x   [NLANE],
    input  logic [CB-1:0]  i_d   [NLANE],
    input  logic [FB+1:0]  i_q   [NLANE],
    input  logic [NLANE-1:0] i_ovf,
    input  logic [NLANE-1:0] i_neg,
    output logic          o_vld,
    output t_side         o_side,
    output logic [CB:0]    o_rem [NLANE],
    output logic [CB+FB:0] o_x   [NLANE],
    output logic [CB-1:0]  o_d   [NLANE],
    output logic [FB+1:0]  o_q   [NLANE],
    output logic [NLANE-1:0] o_ovf,
    output logic [NLANE-1:0] o_neg
);
    logic [CB:0]    n_rem [NLANE];
    logic [CB+FB:0] n_x   [NLANE];
    logic [FB+1:0]  n_q   [NLANE];
    logic [NLANE-1:0] n_ovf;
    logic [CB:0]    w_t   [NLANE];
    logic [NLANE-1:0] w_ge;

    logic          r_vld;
    t_side         r_side;
    logic [CB:0]    r_rem [NLANE];
    logic [CB+FB:0] r_x   [NLANE];
    logic [CB-1:0]  r_d   [NLANE];
    logic [FB+1:0]  r_q   [NLANE];
    logic [NLANE-1:0] r_ovf;
    logic [NLANE-1:0] r_neg;

    // shift in next dividend bit, subtract divisor when it fits
    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            w_t[l]   = {i_rem[l][CB-1:0], i_x[l][CB+FB]};
            w_ge[l]  = (w_t[l] >= {1'b0, i_d[l]});
            n_rem[l] = w_ge[l] ? (w_t[l] - {1'b0, i_d[l]}) : w_t[l];
            n_x[l]   = {i_x[l][CB+FB-1:0], 1'b0};
            n_q[l]   = {i_q[l][FB:0], w_ge[l]};
            n_ovf[l] = i_ovf[l] | i_q[l][FB+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_rem  <= n_rem;
            r_x    <= n_x;
            r_d    <= i_d;
            r_q    <= n_q;
            r_ovf  <= n_ovf;
            r_neg  <= i_neg;
        end
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_rem  = r_rem;
    assign o_x    = r_x;
    assign o_d    = r_d;
    assign o_q    = r_q;
    assign o_ovf  = r_ovf;
    assign o_neg  = r_neg;
endmodule

### rtl/sbct_check.sv
// Port-level checks on the result channel.
module sbct_check
    import sbct_pkg::*;
#(
    parameter int FB = 16
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              i_ready,
    input logic              i_hit,
    input logic [FB:0]       i_entry_time,
    input logic signed [1:0] i_normal_x,
    input logic signed [1:0] i_normal_y
);
    localparam logic [FB:0] ONE = (FB+1)'(1) << FB;

    // held word stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable({i_hit, i_entry_time, i_normal_x, i_normal_y}))
        else $error("output word changed while stalled");

    // a miss carries all-zero fields
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_hit |-> i_entry_time == '0 && i_normal_x == NORM_NONE
                              && i_normal_y == NORM_NONE)
        else $error("miss with nonzero fields");

    // a hit has exactly one axis normal, never the unused code
    a_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_hit |-> ((i_normal_x != NORM_NONE) != (i_normal_y != NORM_NONE))
                             && i_normal_x != 2'sb10 && i_normal_y != 2'sb10)
        else $error("bad contact normal");

    // entry time within the frame
    a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_hit |-> i_entry_time <= ONE)
        else $error("entry time above one");
endmodule

bind swept_box_collision_time_top sbct_check #(.FB(TIME_FRAC_BITS)) u_sbct_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_out.valid),
    .i_ready     (o_out.ready),
    .i_hit       (o_out.hit),
    .i_entry_time(o_out.entry_time),
    .i_normal_x  (o_out.normal_x),
    .i_normal_y  (o_out.normal_y)
);
